[rtl/core/cec_pkg.sv]
`default_nettype none
package cec_pkg;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int DATA_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SUM_W   = 37;
  localparam int SIZE_W  = 7;
  localparam int KSIZE_W = 3;
  localparam int CFG_IDX_W = 2;
  // Pixel coordinate plus kernel offset, signed; covers -3..66.
  localparam int POS_W   = 8;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_KERNEL = 7;

  localparam logic [SIZE_W-1:0]  RST_PLANE_WIDTH  = 7'd64;
  localparam logic [SIZE_W-1:0]  RST_PLANE_HEIGHT = 7'd64;
  localparam logic [KSIZE_W-1:0] RST_KERNEL_ROWS  = 3'd3;
  localparam logic [KSIZE_W-1:0] RST_KERNEL_COLS  = 3'd3;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_COEF    = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_WIDTH  = 2'd0,
    CFG_PLANE_HEIGHT = 2'd1,
    CFG_KERNEL_ROWS  = 2'd2,
    CFG_KERNEL_COLS  = 2'd3
  } cfg_idx_t;

  // One kernel tap travelling from the sequencer into the MAC pipeline.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tap_t;

  // A size of zero counts as one; anything above the store limit saturates.
  function automatic logic [SIZE_W-1:0] limit_size(logic [SIZE_W-1:0] v, int hi);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (32'(v) > hi) begin
      res = SIZE_W'(hi);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/core/cec_ram.sv]
`default_nettype none
module cec_ram #(
  parameter int WIDTH = cec_pkg::DATA_W,
  parameter int DEPTH = cec_pkg::DEF_MAX_WIDTH * cec_pkg::DEF_MAX_HEIGHT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/core/cec_ctrl.sv]
`default_nettype none
module cec_ctrl #(
  parameter int MAX_WIDTH  = cec_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cec_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = cec_pkg::DEF_MAX_KERNEL,
  parameter int PIX_AW     = $clog2(MAX_WIDTH * MAX_HEIGHT),
  parameter int COEF_AW    = $clog2(MAX_KERNEL * MAX_KERNEL)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_kind,
  input  wire logic [cec_pkg::ROW_W-1:0]           in_row,
  input  wire logic [cec_pkg::COL_W-1:0]           in_col,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cec_pkg::SIZE_W-1:0]          cfg_data,
  input  wire logic                                mac_busy,
  output logic                                     pix_wr_en,
  output logic [PIX_AW-1:0]                        pix_wr_addr,
  output logic [PIX_AW-1:0]                        pix_rd_addr,
  output logic                                     coef_wr_en,
  output logic [COEF_AW-1:0]                       coef_wr_addr,
  output logic [COEF_AW-1:0]                       coef_rd_addr,
  output cec_pkg::tap_t                            tap
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t state_r, state_nxt;

  logic [cec_pkg::SIZE_W-1:0]  cfg_width_r, cfg_height_r;
  logic [cec_pkg::KSIZE_W-1:0] cfg_krows_r, cfg_kcols_r;

  logic [cec_pkg::SIZE_W-1:0]  width_r, height_r;
  logic [cec_pkg::KSIZE_W-1:0] krows_r, kcols_r;
  logic [cec_pkg::ROW_W-1:0]   row_r;
  logic [cec_pkg::COL_W-1:0]   col_r;
  logic [cec_pkg::KSIZE_W-1:0] j_r, j_nxt, k_r, k_nxt;
  logic [cec_pkg::SIZE_W-1:0]  krows_lim, kcols_lim;

  logic in_acc, first_tap, last_tap, issue;
  logic signed [cec_pkg::POS_W-1:0] row_pos, col_pos;
  logic [cec_pkg::SIZE_W-1:0] pr, pc;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Store writes happen only while idle, so they never meet a tap read.
  assign pix_wr_en  = in_acc && (in_kind == cec_pkg::KIND_PIXEL) &&
                      (32'(in_row) < MAX_HEIGHT) && (32'(in_col) < MAX_WIDTH);
  assign coef_wr_en = in_acc && (in_kind == cec_pkg::KIND_COEF) &&
                      (32'(in_row) < MAX_KERNEL) && (32'(in_col) < MAX_KERNEL);
  assign pix_wr_addr  = PIX_AW'(32'(in_row) * MAX_WIDTH + 32'(in_col));
  assign coef_wr_addr = COEF_AW'(32'(in_row) * MAX_KERNEL + 32'(in_col));

  assign krows_lim = cec_pkg::limit_size({4'b0000, cfg_krows_r}, MAX_KERNEL);
  assign kcols_lim = cec_pkg::limit_size({4'b0000, cfg_kcols_r}, MAX_KERNEL);

  assign first_tap = (j_r == '0) && (k_r == '0);
  assign last_tap  = (j_r == krows_r - 3'd1) && (k_r == kcols_r - 3'd1);
  // The first tap waits until the MAC pipeline and output word are free.
  assign issue     = (state_r == S_RUN) && (!first_tap || !mac_busy);

  always_comb begin
    row_pos = $signed({2'b00, row_r}) + $signed({5'b00000, j_r})
            - $signed({6'b000000, krows_r[2:1]});
    col_pos = $signed({2'b00, col_r}) + $signed({5'b00000, k_r})
            - $signed({6'b000000, kcols_r[2:1]});
    if (row_pos < 0) begin
      pr = '0;
    end else if (row_pos[6:0] > height_r - 7'd1) begin
      pr = height_r - 7'd1;
    end else begin
      pr = row_pos[6:0];
    end
    if (col_pos < 0) begin
      pc = '0;
    end else if (col_pos[6:0] > width_r - 7'd1) begin
      pc = width_r - 7'd1;
    end else begin
      pc = col_pos[6:0];
    end
  end

  assign pix_rd_addr  = PIX_AW'(32'(pr) * MAX_WIDTH + 32'(pc));
  assign coef_rd_addr = COEF_AW'(32'(j_r) * MAX_KERNEL + 32'(k_r));

  assign tap.vld   = issue;
  assign tap.first = first_tap;
  assign tap.last  = last_tap;
  assign tap.row   = row_r;
  assign tap.col   = col_r;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == cec_pkg::KIND_COMPUTE)) begin
          state_nxt = S_RUN;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      S_RUN: begin
        if (issue) begin
          if (last_tap) begin
            state_nxt = S_IDLE;
          end else if (k_r == kcols_r - 3'd1) begin
            k_nxt = '0;
            j_nxt = j_r + 3'd1;
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_width_r  <= cec_pkg::RST_PLANE_WIDTH;
      cfg_height_r <= cec_pkg::RST_PLANE_HEIGHT;
      cfg_krows_r  <= cec_pkg::RST_KERNEL_ROWS;
      cfg_kcols_r  <= cec_pkg::RST_KERNEL_COLS;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cec_pkg::CFG_PLANE_WIDTH:  cfg_width_r  <= cfg_data;
          cec_pkg::CFG_PLANE_HEIGHT: cfg_height_r <= cfg_data;
          cec_pkg::CFG_KERNEL_ROWS:  cfg_krows_r  <= cfg_data[2:0];
          cec_pkg::CFG_KERNEL_COLS:  cfg_kcols_r  <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
    k_r <= k_nxt;
    if (in_acc && (in_kind == cec_pkg::KIND_COMPUTE)) begin
      row_r    <= in_row;
      col_r    <= in_col;
      width_r  <= cec_pkg::limit_size(cfg_width_r, MAX_WIDTH);
      height_r <= cec_pkg::limit_size(cfg_height_r, MAX_HEIGHT);
      krows_r  <= krows_lim[cec_pkg::KSIZE_W-1:0];
      kcols_r  <= kcols_lim[cec_pkg::KSIZE_W-1:0];
    end
  end

  a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> !pix_wr_en && !coef_wr_en)
    else $error("store write during a tap sweep");

  a_taps_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && !last_tap) |=> issue)
    else $error("tap sweep stalled after its first tap");

  a_tap_in_kernel: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (j_r < krows_r) && (k_r < kcols_r))
    else $error("tap counter left the kernel");

endmodule
`default_nettype wire

[rtl/core/cec_mac.sv]
`default_nettype none
module cec_mac (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cec_pkg::tap_t                     tap,
  input  wire logic signed [cec_pkg::DATA_W-1:0] pix_rd,
  input  wire logic signed [cec_pkg::DATA_W-1:0] coef_rd,
  output logic                                   mac_busy,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [cec_pkg::ROW_W-1:0]              out_row,
  output logic [cec_pkg::COL_W-1:0]              out_col,
  output logic [cec_pkg::SUM_W-1:0]              out_sum
);

  cec_pkg::tap_t t1_r, t2_r;
  logic signed [cec_pkg::PROD_W-1:0] prod_r;
  logic [cec_pkg::SUM_W-1:0] acc_r, acc_nxt;
  logic                      out_valid_r;
  logic [cec_pkg::ROW_W-1:0] out_row_r;
  logic [cec_pkg::COL_W-1:0] out_col_r;
  logic [cec_pkg::SUM_W-1:0] out_sum_r;

  always_comb begin
    acc_nxt = (t2_r.first ? '0 : acc_r)
            + {{(cec_pkg::SUM_W - cec_pkg::PROD_W){prod_r[cec_pkg::PROD_W-1]}}, prod_r};
  end

  assign mac_busy  = t1_r.vld || t2_r.vld || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_sum   = out_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.vld    <= 1'b0;
      t2_r.vld    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      t1_r.vld <= tap.vld;
      t2_r.vld <= t1_r.vld;
      if (t2_r.vld && t2_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    t1_r.first <= tap.first;
    t1_r.last  <= tap.last;
    t1_r.row   <= tap.row;
    t1_r.col   <= tap.col;
    t2_r.first <= t1_r.first;
    t2_r.last  <= t1_r.last;
    t2_r.row   <= t1_r.row;
    t2_r.col   <= t1_r.col;
  end

  always_ff @(posedge clk) begin
    // Memory data is registered in the RAM and arrives in the cycle after the tap address.
    prod_r <= coef_rd * pix_rd;
    if (t2_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (t2_r.vld && t2_r.last) begin
      out_sum_r <= acc_nxt;
      out_row_r <= t2_r.row;
      out_col_r <= t2_r.col;
    end
  end

  a_out_free_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (t2_r.vld && t2_r.last) |-> !out_valid_r)
    else $error("result loaded over an unread result");

  a_first_tap_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (tap.vld && tap.first) |-> !t1_r.vld && !t2_r.vld && !out_valid_r)
    else $error("new sweep started while the pipeline was busy");

  a_accum_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (t2_r.vld && !t2_r.last) |=> t2_r.vld && !t2_r.first)
    else $error("accumulation broken inside one output");

endmodule
`default_nettype wire

[rtl/core/clamped_edge_conv2d.sv]
// Write items (pixel or coefficient) are accepted while idle; kind 3 is accepted and dropped.
// A compute item holds in_tready low until its last tap issues; after its first tap it steps
// one tap per cycle through the single pixel memory read port and one shared 16x16 MAC.
// Its result goes from the last tap read through the product register into the output register;
// a new compute's first tap waits for the MAC to drain and the earlier result to be taken.
// Reset (rst_n, synchronous) restores the registers to 64x64 plane, 3x3 kernel; stores keep data.
`default_nettype none
module clamped_edge_conv2d #(
  parameter int MAX_WIDTH  = cec_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cec_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = cec_pkg::DEF_MAX_KERNEL
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [5:0] row_index, [11:6] col_index, [27:12] data_value, [31:28] zero
  input  wire logic [31:0] in_tdata,
  // [1:0] kind
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [5:0] out_row, [11:6] out_col, [48:12] weighted_sum, [55:49] zero
  output logic [55:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [cec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cec_pkg::SIZE_W-1:0]    cfg_data
);

  localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int PIX_AW     = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

  logic                                pix_wr_en, coef_wr_en, mac_busy;
  logic [PIX_AW-1:0]                   pix_wr_addr, pix_rd_addr;
  logic [COEF_AW-1:0]                  coef_wr_addr, coef_rd_addr;
  logic [cec_pkg::DATA_W-1:0]          pix_rd, coef_rd, in_data;
  cec_pkg::tap_t                       tap;
  logic [cec_pkg::ROW_W-1:0]           res_row;
  logic [cec_pkg::COL_W-1:0]           res_col;
  logic [cec_pkg::SUM_W-1:0]           res_sum;

  assign in_data = in_tdata[27:12];

  cec_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_KERNEL(MAX_KERNEL),
    .PIX_AW    (PIX_AW),
    .COEF_AW   (COEF_AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_row      (in_tdata[5:0]),
    .in_col      (in_tdata[11:6]),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mac_busy    (mac_busy),
    .pix_wr_en   (pix_wr_en),
    .pix_wr_addr (pix_wr_addr),
    .pix_rd_addr (pix_rd_addr),
    .coef_wr_en  (coef_wr_en),
    .coef_wr_addr(coef_wr_addr),
    .coef_rd_addr(coef_rd_addr),
    .tap         (tap)
  );

  cec_ram #(
    .WIDTH(cec_pkg::DATA_W),
    .DEPTH(PIX_DEPTH),
    .AW   (PIX_AW)
  ) u_pix_ram (
    .clk    (clk),
    .wr_en  (pix_wr_en),
    .wr_addr(pix_wr_addr),
    .wr_data(in_data),
    .rd_addr(pix_rd_addr),
    .rd_data(pix_rd)
  );

  cec_ram #(
    .WIDTH(cec_pkg::DATA_W),
    .DEPTH(COEF_DEPTH),
    .AW   (COEF_AW)
  ) u_coef_ram (
    .clk    (clk),
    .wr_en  (coef_wr_en),
    .wr_addr(coef_wr_addr),
    .wr_data(in_data),
    .rd_addr(coef_rd_addr),
    .rd_data(coef_rd)
  );

  cec_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .tap      (tap),
    .pix_rd   (pix_rd),
    .coef_rd  (coef_rd),
    .mac_busy (mac_busy),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_row  (res_row),
    .out_col  (res_col),
    .out_sum  (res_sum)
  );

  assign out_tdata = {7'b0000000, res_sum, res_col, res_row};

endmodule
`default_nettype wire

[tb/sv/tb_clamped_edge_conv2d.sv]
`timescale 1ns / 1ps

module tb_clamped_edge_conv2d;
  import cec_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PLANE_MAX = DEF_MAX_WIDTH;
  localparam int KERN_MAX = DEF_MAX_KERNEL;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [SUM_W-1:0] sum;
  } conv_result_t;

  class conv_scoreboard;
    logic signed [DATA_W-1:0] pixels [PLANE_MAX][PLANE_MAX];
    logic signed [DATA_W-1:0] coefs [KERN_MAX][KERN_MAX];
    bit pix_written [PLANE_MAX][PLANE_MAX];
    bit coef_written [KERN_MAX][KERN_MAX];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [KSIZE_W-1:0] krows_reg;
    logic [KSIZE_W-1:0] kcols_reg;
    conv_result_t sums_due [$];
    int fails;
    int reported;
    int results_seen;
    int live_items;
    int writes_seen;

    function new();
      width_reg = RST_PLANE_WIDTH;
      height_reg = RST_PLANE_HEIGHT;
      krows_reg = RST_KERNEL_ROWS;
      kcols_reg = RST_KERNEL_COLS;
    endfunction

    function int clip(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int clamp(int v, int size);
      if (v < 0) return 0;
      if (v > size - 1) return size - 1;
      return v;
    endfunction

    function int plane_w();
      return clip(int'(width_reg), PLANE_MAX);
    endfunction

    function int plane_h();
      return clip(int'(height_reg), PLANE_MAX);
    endfunction

    function int kern_rows();
      return clip(int'(krows_reg), KERN_MAX);
    endfunction

    function int kern_cols();
      return clip(int'(kcols_reg), KERN_MAX);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      case (idx)
        CFG_PLANE_WIDTH: width_reg = val;
        CFG_PLANE_HEIGHT: height_reg = val;
        CFG_KERNEL_ROWS: krows_reg = val[KSIZE_W-1:0];
        CFG_KERNEL_COLS: kcols_reg = val[KSIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function void flag(string what);
      fails++;
      if (reported < 10) begin
        reported++;
        $display("MISMATCH at %0t: %s", $realtime, what);
      end
    endfunction

    function void note_input(logic [1:0] kind, logic [ROW_W-1:0] row,
                             logic [COL_W-1:0] col, logic signed [DATA_W-1:0] data);
      conv_result_t res;
      longint acc;
      int kr, kc, w, h, pr, pc;
      case (kind)
        KIND_PIXEL: begin
          pixels[row][col] = data;
          pix_written[row][col] = 1'b1;
          writes_seen++;
          live_items++;
        end
        KIND_COEF: begin
          // Coefficient writes outside the 7x7 store are dropped.
          if (row < KERN_MAX && col < KERN_MAX) begin
            coefs[row][col] = data;
            coef_written[row][col] = 1'b1;
            writes_seen++;
            live_items++;
          end
        end
        KIND_COMPUTE: begin
          kr = kern_rows();
          kc = kern_cols();
          w = plane_w();
          h = plane_h();
          acc = 0;
          for (int j = 0; j < kr; j++) begin
            pr = clamp(int'(row) + j - kr / 2, h);
            for (int k = 0; k < kc; k++) begin
              pc = clamp(int'(col) + k - kc / 2, w);
              acc += longint'(coefs[j][k]) * longint'(pixels[pr][pc]);
            end
          end
          res.row = row;
          res.col = col;
          res.sum = acc[SUM_W-1:0];
          sums_due.push_back(res);
          live_items++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [55:0] word);
      conv_result_t got;
      conv_result_t want;
      got.row = word[5:0];
      got.col = word[11:6];
      got.sum = word[48:12];
      results_seen++;
      if (sums_due.size() == 0) begin
        flag($sformatf("result (%0d,%0d) sum %0d with none outstanding",
                       got.row, got.col, $signed(got.sum)));
      end else begin
        want = sums_due.pop_front();
        if (got.row !== want.row)
          flag($sformatf("out_row expected %0d got %0d", want.row, got.row));
        if (got.col !== want.col)
          flag($sformatf("out_col expected %0d got %0d", want.col, got.col));
        if (got.sum !== want.sum)
          flag($sformatf("weighted_sum at (%0d,%0d) expected %0d got %0d",
                         want.row, want.col, $signed(want.sum), $signed(got.sum)));
      end
    endfunction

    function int pending();
      return sums_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // [5:0] row_index, [11:6] col_index, [27:12] data_value, [31:28] zero
  logic [31:0] in_tdata = '0;
  // [1:0] kind
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [5:0] out_row, [11:6] out_col, [48:12] weighted_sum, [55:49] zero
  logic [55:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int settings_seen = 0;
  conv_scoreboard board = new();

  clamped_edge_conv2d uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata);
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'h8000;
    if (roll < 20) return 16'h7FFF;
    if (roll < 25) return 16'h0000;
    return DATA_W'($urandom);
  endfunction

  // Output positions cluster on the edges and near the origin so that the
  // pixels written for one compute are reused by the next.
  function automatic int pick_pos(int size);
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return $urandom_range(63);
    if (roll < 35) return 0;
    if (roll < 45) return size - 1;
    if (roll < 50) return (size > 1) ? size - 2 : 0;
    if (roll < 55) return 63;
    return $urandom_range((size < 10) ? size - 1 : 9);
  endfunction

  task automatic send_word(logic [1:0] kind, int row, int col, logic [DATA_W-1:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'b0, data, COL_W'(col), ROW_W'(row)};
    do @(posedge clk); while (!in_tready);
    board.note_input(kind, ROW_W'(row), COL_W'(col), data);
  endtask

  // Any tap the compute will read that has not been written yet is filled first.
  task automatic send_compute(int r, int c);
    int kr, kc, w, h, pr, pc;
    kr = board.kern_rows();
    kc = board.kern_cols();
    w = board.plane_w();
    h = board.plane_h();
    for (int j = 0; j < kr; j++) begin
      for (int k = 0; k < kc; k++) begin
        if (!board.coef_written[j][k]) send_word(KIND_COEF, j, k, rand_word());
      end
    end
    for (int j = 0; j < kr; j++) begin
      pr = board.clamp(r + j - kr / 2, h);
      for (int k = 0; k < kc; k++) begin
        pc = board.clamp(c + k - kc / 2, w);
        if (!board.pix_written[pr][pc]) send_word(KIND_PIXEL, pr, pc, rand_word());
      end
    end
    send_word(KIND_COMPUTE, r, c, DATA_W'($urandom));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
  endtask

  task automatic apply_setting(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                               logic [SIZE_W-1:0] kr, logic [SIZE_W-1:0] kc);
    write_reg(CFG_PLANE_WIDTH, w);
    write_reg(CFG_PLANE_HEIGHT, h);
    write_reg(CFG_KERNEL_ROWS, kr);
    write_reg(CFG_KERNEL_COLS, kc);
    cfg_valid <= 1'b0;
    settings_seen++;
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int roll;
    roll = $urandom_range(99);
    if (roll < 38) begin
      send_compute(pick_pos(board.plane_h()), pick_pos(board.plane_w()));
    end else if (roll < 70) begin
      send_word(KIND_PIXEL, $urandom_range(board.plane_h() - 1),
                $urandom_range(board.plane_w() - 1), rand_word());
    end else if (roll < 88) begin
      if ($urandom_range(99) < 85)
        send_word(KIND_COEF, $urandom_range(KERN_MAX - 1), $urandom_range(KERN_MAX - 1),
                  rand_word());
      else
        send_word(KIND_COEF, $urandom_range(63), $urandom_range(63), rand_word());
    end else if (roll < 93) begin
      send_word(KIND_UNUSED, $urandom_range(63), $urandom_range(63), DATA_W'($urandom));
    end else begin
      send_word(KIND_PIXEL, $urandom_range(63), $urandom_range(63), rand_word());
    end
  endtask

  task automatic run_phase(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                           logic [SIZE_W-1:0] kr, logic [SIZE_W-1:0] kc, int count);
    int target;
    quiesce();
    apply_setting(w, h, kr, kc);
    target = board.live_items + count;
    while (board.live_items < target) random_item();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 2x2 plane with a full 3x3 kernel of coefficients including the extremes.
    apply_setting(7'd2, 7'd2, 7'd3, 7'd3);
    send_word(KIND_COEF, 0, 0, 16'h7FFF);
    send_word(KIND_COEF, 0, 1, 16'h8000);
    send_word(KIND_COEF, 0, 2, 16'h0001);
    send_word(KIND_COEF, 1, 0, 16'hFFFF);
    send_word(KIND_COEF, 1, 1, 16'h4000);
    send_word(KIND_COEF, 1, 2, 16'hC000);
    send_word(KIND_COEF, 2, 0, 16'h0000);
    send_word(KIND_COEF, 2, 1, 16'h3039);
    send_word(KIND_COEF, 2, 2, 16'h8000);
    send_word(KIND_PIXEL, 0, 0, 16'h8000);
    send_word(KIND_PIXEL, 0, 1, 16'h7FFF);
    send_word(KIND_PIXEL, 1, 0, 16'hFFFF);
    send_word(KIND_PIXEL, 1, 1, 16'h0001);
    send_word(KIND_PIXEL, 63, 63, 16'h0064);
    // Coefficient writes outside the kernel store and an unused kind are dropped.
    send_word(KIND_COEF, 7, 0, 16'h0005);
    send_word(KIND_COEF, 63, 63, 16'hFFFF);
    send_word(KIND_UNUSED, 63, 63, 16'h7FFF);
    send_compute(0, 0);
    send_compute(1, 1);
    send_compute(0, 1);
    // Positions beyond the plane still clamp every tap inside it.
    send_compute(63, 63);
    send_compute(1, 63);

    send_idle_pct = 37;
    recv_idle_pct = 78;
    run_phase(7'd8, 7'd6, 7'd3, 7'd3, 200);
    run_phase(7'd1, 7'd1, 7'd7, 7'd7, 150);
    run_phase(7'd64, 7'd64, 7'd1, 7'd1, 150);

    send_idle_pct = 78;
    recv_idle_pct = 37;
    run_phase(7'd0, 7'd0, 7'd0, 7'd0, 100);
    run_phase(7'd127, 7'd100, 7'd5, 7'd2, 200);
    run_phase(SIZE_W'($urandom_range(1, 16)), SIZE_W'($urandom_range(1, 16)),
              SIZE_W'($urandom), SIZE_W'($urandom), 200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(7'd7, 7'd13, 7'd4, 7'd6, 200);
    run_phase(7'd64, 7'd64, 7'd7, 7'd7, 150);
    run_phase(SIZE_W'($urandom), SIZE_W'($urandom_range(1, 20)),
              SIZE_W'($urandom_range(1, 7)), SIZE_W'($urandom_range(1, 7)), 200);

    quiesce();
    board.fails += board.pending();
    $display("Run summary: %0d convolution results over %0d plane and kernel settings.",
             board.results_seen, settings_seen);
    $display("Run summary: %0d store writes, %0d mismatches.",
             board.writes_seen, board.fails);
    if (board.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Timeout with %0d results outstanding.", board.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
